// ===== design/grain_orientation_update_defines.svh =====
// Assertion macros used by the port checker of grain_orientation_update.
// Each macro states one concurrent property on a clock with a synchronous reset.
`ifndef GRAIN_ORIENTATION_UPDATE_DEFINES_SVH
`define GRAIN_ORIENTATION_UPDATE_DEFINES_SVH

// Same-cycle implication: when ante holds at a clock edge, cons holds there too.
`define GOU_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grain_orientation_update: port property failed");

// Next-cycle implication: when ante holds at a clock edge, cons holds at the next one.
`define GOU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grain_orientation_update: port property failed");

`endif

// ===== design/gou_pkg.sv =====
// Package of the grain orientation update block: sizes, word types and helpers.
// Used by every module of the block and by its port checker; depends on nothing.
package gou_pkg;

   localparam int GRID_SIDE      = 64;
   localparam int ORIENT_BITS    = 8;
   localparam int DEPTH          = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W         = $clog2(DEPTH);

   localparam int COORD_W        = 6;
   localparam int FIELD_ORIENT_W = 8;
   localparam int RAND_W         = 16;
   localparam int POS_W          = COORD_W + 2;

   localparam int NB_NUM         = 8;
   localparam int NB_IDX_W       = $clog2(NB_NUM);
   localparam int CNT_W          = $clog2(NB_NUM + 1);
   localparam int SLOT_W         = $clog2(NB_NUM + 1);
   localparam int MOD_W          = CNT_W + 2;
   localparam int RAND_STEPS     = RAND_W / 2;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   // Items that can be inside the block at once: queue, the one at work, the held result.
   localparam int OUTSTANDING_MAX = QUEUE_DEPTH + 2;
   localparam int PEND_W          = $clog2(OUTSTANDING_MAX + 1);

   // Neighbor offsets (row, column), in the fixed candidate order.
   localparam logic signed [1:0] NB_DX [NB_NUM] = '{
      2'sb00, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb01, 2'sb11, 2'sb11
   };
   localparam logic signed [1:0] NB_DY [NB_NUM] = '{
      2'sb01, 2'sb11, 2'sb00, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb11
   };

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_EVAL  = 1'b1
   } action_type;

   typedef struct packed {
      action_type                action;
      logic [COORD_W-1:0]        cell_x;
      logic [COORD_W-1:0]        cell_y;
      logic [FIELD_ORIENT_W-1:0] orientation;
      logic [RAND_W-1:0]         random_word;
      logic                      coin;
   } gou_req_type;

   typedef struct packed {
      logic [FIELD_ORIENT_W-1:0] proposed_orientation;
      logic                      viable;
      logic                      changed;
   } gou_rsp_type;

   // A classified item as it waits between the front and the back.
   typedef struct packed {
      action_type             action;
      logic                   center_ok;
      logic [COORD_W-1:0]     cell_x;
      logic [COORD_W-1:0]     cell_y;
      logic [ORIENT_BITS-1:0] orientation;
      logic [NB_NUM-1:0]      nb_mask;
      logic [CNT_W-1:0]       nb_count;
      logic [RAND_W-1:0]      random_word;
      logic                   coin;
   } gou_job_type;

   function automatic logic signed [POS_W-1:0] nb_pos(
      input logic [COORD_W-1:0] base,
      input logic signed [1:0]  off
   );
      return $signed({2'b00, base}) + POS_W'(off);
   endfunction

   function automatic logic pos_in_grid(input logic signed [POS_W-1:0] pos);
      return (pos >= 0) && (pos < GRID_SIDE);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(
      input logic signed [POS_W-1:0] row,
      input logic signed [POS_W-1:0] col
   );
      return ADDR_W'(int'(row) * GRID_SIDE + int'(col));
   endfunction

   // One radix-4 step of a remainder by a small divisor: the remainder stays below it.
   function automatic logic [NB_IDX_W-1:0] mod_step(
      input logic [NB_IDX_W-1:0] rem,
      input logic [1:0]          digit,
      input logic [CNT_W-1:0]    divisor
   );
      logic [MOD_W-1:0] t;
      logic [MOD_W-1:0] d1;
      logic [MOD_W-1:0] d2;
      logic [MOD_W-1:0] d3;
      logic [MOD_W-1:0] r;
      t  = MOD_W'({rem, digit});
      d1 = MOD_W'(divisor);
      d2 = d1 << 1;
      d3 = d1 + d2;
      if (t >= d3) begin
         r = t - d3;
      end else if (t >= d2) begin
         r = t - d2;
      end else if (t >= d1) begin
         r = t - d1;
      end else begin
         r = t;
      end
      return NB_IDX_W'(r);
   endfunction

endpackage

// ===== design/gou_front.sv =====
// Front of the grain orientation update block: classifies an incoming word.
// Depends on gou_pkg for the word types and the neighbor geometry.
module gou_front (
   input  gou_pkg::gou_req_type req_data,
   output gou_pkg::gou_job_type job_data
);
   import gou_pkg::*;

   logic [NB_NUM-1:0] nb_mask;
   logic [CNT_W-1:0]  nb_count;

   // A neighbor is a candidate only when both of its coordinates fall inside the grid.
   always_comb begin
      nb_mask  = '0;
      nb_count = '0;
      for (int k = 0; k < NB_NUM; k++) begin
         nb_mask[k] = pos_in_grid(nb_pos(req_data.cell_x, NB_DX[k])) &&
                      pos_in_grid(nb_pos(req_data.cell_y, NB_DY[k]));
         nb_count   = nb_count + CNT_W'(nb_mask[k]);
      end
   end

   always_comb begin
      job_data.action      = req_data.action;
      job_data.center_ok   = pos_in_grid(nb_pos(req_data.cell_x, 2'sb00)) &&
                             pos_in_grid(nb_pos(req_data.cell_y, 2'sb00));
      job_data.cell_x      = req_data.cell_x;
      job_data.cell_y      = req_data.cell_y;
      job_data.orientation = ORIENT_BITS'(req_data.orientation);
      job_data.nb_mask     = nb_mask;
      job_data.nb_count    = nb_count;
      job_data.random_word = req_data.random_word;
      job_data.coin        = req_data.coin;
   end

endmodule

// ===== design/gou_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on gou_pkg for the item type and the queue depth.
module gou_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gou_pkg::gou_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output gou_pkg::gou_job_type pop_data,
   output logic                 empty
);
   import gou_pkg::*;

   gou_job_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/gou_back.sv =====
// Back of the grain orientation update block: grid memory, read sequencer,
// energy bookkeeping, candidate pick and the result register. Depends on gou_pkg.
module gou_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  gou_pkg::gou_job_type job_data,
   output logic                 job_pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gou_pkg::gou_rsp_type rsp_data
);
   import gou_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_LAST   = 5'b01000,
      ST_DECIDE = 5'b10000
   } back_state_type;

   logic [ORIENT_BITS-1:0] grid_mem [DEPTH];

   back_state_type         state_ff, state_in;
   logic [ADDR_W-1:0]      clear_addr_ff, clear_addr_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      rd_slot_ff;
   logic                   rd_live_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   gou_job_type            job_ff;
   logic [RAND_W-1:0]      rand_ff;
   logic [NB_IDX_W-1:0]    rem_ff;
   logic [ORIENT_BITS-1:0] rd_data_ff;
   logic [ORIENT_BITS-1:0] own_ff;
   logic [ORIENT_BITS-1:0] nb_val_ff [NB_NUM];
   logic [CNT_W-1:0]       nb_match_ff [NB_NUM];
   logic [CNT_W-1:0]       nb_match_in [NB_NUM];
   logic [CNT_W-1:0]       own_match_ff, own_match_in;
   gou_rsp_type            rsp_data_ff, rsp_data_in;

   // Read side: slot zero reads the cell itself, slot k reads neighbor k-1.
   logic                    slot_center;
   logic [NB_IDX_W-1:0]     slot_nb;
   logic signed [1:0]       off_x, off_y;
   logic signed [POS_W-1:0] rd_row, rd_col;
   logic                    rd_ok;
   logic [ADDR_W-1:0]       rd_addr;
   logic [SLOT_W-1:0]       slot_last;

   assign slot_center = (slot_ff == '0);
   assign slot_nb     = NB_IDX_W'(slot_ff - SLOT_W'(1));
   assign off_x       = slot_center ? 2'sb00 : NB_DX[slot_nb];
   assign off_y       = slot_center ? 2'sb00 : NB_DY[slot_nb];
   assign rd_row      = nb_pos(job_ff.cell_x, off_x);
   assign rd_col      = nb_pos(job_ff.cell_y, off_y);
   assign rd_ok       = slot_center ? job_ff.center_ok : job_ff.nb_mask[slot_nb];
   assign rd_addr     = rd_ok ? cell_addr(rd_row, rd_col) : '0;
   assign slot_last   = (job_ff.action == ACT_EVAL && job_ff.center_ok) ?
                        SLOT_W'(NB_NUM) : '0;

   // Arrival side: each neighbor value is matched against the ones already in.
   logic                arr_center;
   logic [NB_IDX_W-1:0] arr_nb;
   logic                arr_ok;
   logic [NB_NUM-1:0]   arr_eq;
   logic [CNT_W-1:0]    arr_hits;

   assign arr_center = (rd_slot_ff == '0);
   assign arr_nb     = NB_IDX_W'(rd_slot_ff - SLOT_W'(1));
   assign arr_ok     = rd_live_ff && !arr_center && job_ff.nb_mask[arr_nb];

   always_comb begin
      arr_hits = '0;
      for (int i = 0; i < NB_NUM; i++) begin
         arr_eq[i] = (NB_IDX_W'(i) < arr_nb) && job_ff.nb_mask[i] &&
                     (nb_val_ff[i] == rd_data_ff);
         arr_hits  = arr_hits + CNT_W'(arr_eq[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NB_NUM; i++) begin
         nb_match_in[i] = nb_match_ff[i];
      end
      own_match_in = own_match_ff;
      if (job_pop) begin
         for (int i = 0; i < NB_NUM; i++) begin
            nb_match_in[i] = '0;
         end
         own_match_in = '0;
      end else if (arr_ok) begin
         for (int i = 0; i < NB_NUM; i++) begin
            if (arr_eq[i]) begin
               nb_match_in[i] = nb_match_ff[i] + CNT_W'(1);
            end
         end
         nb_match_in[arr_nb] = arr_hits + CNT_W'(1);
         own_match_in        = own_match_ff + CNT_W'(rd_data_ff == own_ff);
      end
   end

   // Decision. An energy compares as the reverse of its match count, since both
   // are taken over the same set of in-grid neighbors.
   logic                   dec_viable;
   logic                   dec_found;
   logic [NB_IDX_W-1:0]    dec_sel;
   logic [CNT_W-1:0]       dec_rank;
   logic                   dec_take;
   logic [ORIENT_BITS-1:0] dec_prop;
   logic                   dec_flag;
   logic                   dec_changed;
   logic                   dec_write;

   always_comb begin
      dec_viable = 1'b0;
      dec_found  = 1'b0;
      dec_sel    = '0;
      dec_rank   = '0;
      for (int i = 0; i < NB_NUM; i++) begin
         if (job_ff.nb_mask[i] && (nb_val_ff[i] != own_ff) &&
             (nb_match_ff[i] >= own_match_ff)) begin
            dec_viable = 1'b1;
         end
         if (job_ff.nb_mask[i] && !dec_found && (dec_rank == CNT_W'(rem_ff))) begin
            dec_sel   = NB_IDX_W'(i);
            dec_found = 1'b1;
         end
         dec_rank = dec_rank + CNT_W'(job_ff.nb_mask[i]);
      end
      dec_take = (nb_match_ff[dec_sel] > own_match_ff) ||
                 ((nb_match_ff[dec_sel] == own_match_ff) && !job_ff.coin);

      dec_prop    = '0;
      dec_flag    = 1'b0;
      dec_changed = 1'b0;
      dec_write   = 1'b0;
      if (job_ff.center_ok) begin
         if (job_ff.action == ACT_WRITE) begin
            dec_prop    = job_ff.orientation;
            dec_changed = (job_ff.orientation != own_ff);
            dec_write   = 1'b1;
         end else begin
            dec_flag    = dec_viable;
            dec_prop    = (dec_viable && dec_take) ? nb_val_ff[dec_sel] : own_ff;
            dec_changed = dec_viable && (dec_prop != own_ff);
            dec_write   = dec_viable;
         end
      end
      rsp_data_in.proposed_orientation = FIELD_ORIENT_W'(dec_prop);
      rsp_data_in.viable               = dec_flag;
      rsp_data_in.changed              = dec_changed;
   end

   // Sequencer.
   logic decide_fire;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      slot_in       = slot_ff;
      job_pop       = 1'b0;
      decide_fire   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               slot_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (slot_ff == slot_last) begin
               state_in = ST_LAST;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               decide_fire = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign clearing     = (state_ff == ST_CLEAR);
   assign rsp_valid_in = decide_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [ORIENT_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]      center_addr;

   assign center_addr = cell_addr(nb_pos(job_ff.cell_x, 2'sb00),
                                  nb_pos(job_ff.cell_y, 2'sb00));
   assign mem_we      = clearing || (decide_fire && dec_write);
   assign mem_waddr   = clearing ? clear_addr_ff : center_addr;
   assign mem_wdata   = clearing ? '0 : dec_prop;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         slot_ff       <= '0;
         rd_live_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         slot_ff       <= slot_in;
         rd_live_ff    <= (state_ff == ST_READ);
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff  <= job_data;
         rand_ff <= job_data.random_word;
         rem_ff  <= '0;
      end else if ((state_ff == ST_READ) && (slot_ff < SLOT_W'(RAND_STEPS))) begin
         rand_ff <= rand_ff << 2;
         rem_ff  <= mod_step(rem_ff, rand_ff[RAND_W-1 -: 2], job_ff.nb_count);
      end
      if (rd_live_ff && arr_center) begin
         own_ff <= rd_data_ff;
      end
      if (arr_ok) begin
         nb_val_ff[arr_nb] <= rd_data_ff;
      end
      for (int i = 0; i < NB_NUM; i++) begin
         nb_match_ff[i] <= nb_match_in[i];
      end
      own_match_ff <= own_match_in;
      rd_slot_ff   <= slot_ff;
      if (decide_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/grain_orientation_update.sv =====
// An evaluate word's pace is set by the single read port of the grid memory (the cell
// and its eight neighbors are read one per cycle); a write word reads only its own cell.
// The back finishes one word before it takes the next; the queue accepts meanwhile.
// Reset: synchronous, active high. After reset the grid is swept to zero, one cell a
// cycle, over all 4096 cells; req_ready stays low for the whole sweep.
module grain_orientation_update (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gou_pkg::gou_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gou_pkg::gou_rsp_type rsp_data
);
   import gou_pkg::*;

   // The front classifies each word as it arrives: it works out which of the eight
   // neighbors lie inside the grid, how many candidates that makes, and whether the
   // addressed cell itself is inside. None of this needs the grid contents, so it is
   // done before the word is queued.
   gou_job_type front_job;

   gou_front u_front (
      .req_data (req_data),
      .job_data (front_job)
   );

   // A two-word queue decouples acceptance from the back. Words are taken while the
   // back is busy and while a finished result still waits on the output; the queue
   // only closes when it is full or while the grid is being swept after reset.
   logic        queue_push;
   logic        queue_full;
   logic        queue_pop;
   logic        queue_empty;
   gou_job_type queue_job;
   logic        back_clearing;

   assign req_ready  = !queue_full && !back_clearing;
   assign queue_push = req_valid && req_ready;

   gou_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_job),
      .empty     (queue_empty)
   );

   // The back owns the grid memory. It handles one word at a time, strictly in order,
   // so a write-back always lands before the next word reads the grid. For an evaluate
   // word it reads the cell and then each neighbor, keeps for every neighbor value a
   // count of equal neighbors, and meanwhile reduces the random word modulo the candidate
   // count two bits per cycle. The pick, the energy test and the write-back then happen
   // together once the result register is free, and it holds the new result until taken.
   gou_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!queue_empty),
      .job_data  (queue_job),
      .job_pop   (queue_pop),
      .clearing  (back_clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/gou_checker.sv =====
// Port checker for grain_orientation_update, bound to the top level below.
// Depends on gou_pkg and on the assertion macros of the block's defines header.
`include "grain_orientation_update_defines.svh"

module gou_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input gou_pkg::gou_rsp_type rsp_data
);
   import gou_pkg::*;

   // Words accepted whose results have not yet been delivered.
   logic [PEND_W-1:0] pending_ff, pending_in;

   assign pending_in = pending_ff + PEND_W'(req_valid && req_ready)
                                  - PEND_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `GOU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `GOU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `GOU_ASSERT_IMPL(a_no_phantom, clock, reset, rsp_valid, pending_ff != '0)
   `GOU_ASSERT_IMPL(a_capacity, clock, reset, 1'b1, pending_ff <= PEND_W'(OUTSTANDING_MAX))
   `GOU_ASSERT_IMPL(a_sweep_after_reset, clock, reset, $past(reset), !req_ready)

endmodule

bind grain_orientation_update gou_checker u_gou_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== verif/grain_orientation_update_tb.sv =====
// Self-checking testbench for grain_orientation_update: words go in over a queued driver and
// come back to a checking monitor. Depends on gou_pkg and on the grain_orientation_update RTL.
`timescale 1ns / 100ps

module grain_orientation_update_tb;
   import gou_pkg::*;

   // Random stimulus stops once this many words have been queued in total.
   localparam int WORD_TOTAL  = 1050;
   // Watchdog limit. It covers the clearing sweep of the whole grid after reset and every word
   // taking its full evaluate latency, the longest sender gap and the longest receiver
   // stall, with a wide margin on top.
   localparam int CYCLE_LIMIT = 400000;
   // Settling time after the last result.
   localparam int DRAIN_WAIT  = 40;
   // The receiver holds off this long once, so the block fills up and blocks its input.
   localparam int LONG_HOLD   = 300;
   localparam int LONG_HOLD_AT = 400;

   // Neighbor offsets as (row, column), in the fixed order in which candidates are taken.
   localparam int NB_ROW [NB_NUM] = '{0, 0, 1, -1, 1, 1, -1, -1};
   localparam int NB_COL [NB_NUM] = '{1, -1, 0, 0, 1, -1, 1, -1};

   typedef struct {
      gou_req_type word;
      int          gap;
      bit          pause;
   } pending_word_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gou_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gou_rsp_type rsp_data;

   // Words waiting to be offered, and the results the predictor expects, oldest first.
   pending_word_type pending_words [$];
   gou_rsp_type      expected_updates [$];

   // The testbench's own copy of the orientation grid, kept in step with accepted words.
   logic [ORIENT_BITS-1:0] grain_map [GRID_SIDE][GRID_SIDE];

   int  words_built    = 0;
   bit  pause_next     = 1'b0;
   int  idle_count     = 0;
   int  hold_left      = 0;
   int  updates_seen   = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;

   grain_orientation_update DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Number of in-grid neighbors of (x, y) whose orientation differs from cand.
   function automatic int unlike_count(input int x, input int y,
                                       input logic [ORIENT_BITS-1:0] cand);
      int n;
      int i;
      int px;
      int py;
      n = 0;
      for (i = 0; i < NB_NUM; i++) begin
         px = x + NB_ROW[i];
         py = y + NB_COL[i];
         if (px >= 0 && px < GRID_SIDE && py >= 0 && py < GRID_SIDE) begin
            if (grain_map[px][py] != cand) begin
               n++;
            end
         end
      end
      return n;
   endfunction

   // Applies one accepted word to the grid copy and returns the result it must produce.
   function automatic gou_rsp_type grain_step(input gou_req_type w);
      gou_rsp_type            r;
      int                     x;
      int                     y;
      int                     i;
      int                     px;
      int                     py;
      int                     n;
      int                     e_own;
      int                     pick;
      logic                   viable;
      logic [ORIENT_BITS-1:0] own;
      logic [ORIENT_BITS-1:0] cand [NB_NUM];
      int                     energy [NB_NUM];
      r = '0;
      x = w.cell_x;
      y = w.cell_y;
      own = grain_map[x][y];
      if (w.action == ACT_WRITE) begin
         r.proposed_orientation = w.orientation;
         r.changed = (w.orientation != own);
         grain_map[x][y] = w.orientation;
      end else begin
         r.proposed_orientation = own;
         e_own = unlike_count(x, y, own);
         viable = 1'b0;
         n = 0;
         for (i = 0; i < NB_NUM; i++) begin
            px = x + NB_ROW[i];
            py = y + NB_COL[i];
            if (px >= 0 && px < GRID_SIDE && py >= 0 && py < GRID_SIDE) begin
               cand[n] = grain_map[px][py];
               energy[n] = unlike_count(x, y, cand[n]);
               if (energy[n] <= e_own && cand[n] != own) begin
                  viable = 1'b1;
               end
               n++;
            end
         end
         if (viable) begin
            // The random word picks a candidate; it is taken on lower energy, or on equal
            // energy when the coin is zero. A viable step always writes back.
            pick = w.random_word % n;
            if (energy[pick] < e_own || (energy[pick] == e_own && w.coin == 1'b0)) begin
               r.proposed_orientation = cand[pick];
            end
            r.changed = (r.proposed_orientation != own);
            grain_map[x][y] = r.proposed_orientation;
         end
         r.viable = viable;
      end
      return r;
   endfunction

   // Appends one word to the driver's queue with the idle gap that precedes it. Every
   // fourth block of 100 words runs with no gaps at all.
   task automatic queue_word(input action_type act, input int x, input int y,
                             input int orient, input int rand_word, input int coin);
      pending_word_type p;
      p.word.action      = act;
      p.word.cell_x      = COORD_W'(x);
      p.word.cell_y      = COORD_W'(y);
      p.word.orientation = FIELD_ORIENT_W'(orient);
      p.word.random_word = RAND_W'(rand_word);
      p.word.coin        = coin[0];
      p.gap   = ((words_built / 100) % 4 == 1) ? 0 : $urandom_range(0, 15);
      p.pause = pause_next;
      pause_next = 1'b0;
      pending_words.push_back(p);
      words_built++;
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Driver. A word that has been offered stays on the bus until the block takes it; only
   // then does the next one wait out its gap. A word marked as a pause is held back until
   // every result still expected has come back.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         idle_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_updates.push_back(grain_step(req_data));
         end
         if (req_valid && !req_ready) begin
            // Still waiting for the block to take the current word.
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_count < pending_words[0].gap) begin
            idle_count <= idle_count + 1;
            req_valid  <= 1'b0;
         end else if (pending_words[0].pause && expected_updates.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            req_data   <= pending_words[0].word;
            req_valid  <= 1'b1;
            idle_count <= 0;
            pending_words.pop_front();
         end
      end
   end

   // Monitor. Every accepted result is checked against the oldest expectation. After each
   // one the receiver draws a stall; one long hold-off lets the block fill up, and one
   // stretch in three runs with no stalls.
   always @(posedge clock) begin : update_monitor
      int          next_hold;
      gou_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         next_hold = (hold_left > 0) ? hold_left - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               flag_mismatch("unexpected result word", 1, 0);
            end else begin
               want = expected_updates.pop_front();
               if (rsp_data.proposed_orientation !== want.proposed_orientation) begin
                  flag_mismatch("proposed_orientation", rsp_data.proposed_orientation,
                                want.proposed_orientation);
               end
               if (rsp_data.viable !== want.viable) begin
                  flag_mismatch("viable", rsp_data.viable, want.viable);
               end
               if (rsp_data.changed !== want.changed) begin
                  flag_mismatch("changed", rsp_data.changed, want.changed);
               end
            end
            updates_seen++;
            if (updates_seen == LONG_HOLD_AT) begin
               next_hold = LONG_HOLD;
            end else if ((updates_seen / 150) % 3 == 2) begin
               next_hold = 0;
            end else begin
               next_hold = $urandom_range(0, 15);
            end
         end
         hold_left <= next_hold;
         rsp_ready <= (next_hold == 0);
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int                     bx;
      int                     by;
      int                     cx;
      int                     cy;
      int                     npal;
      int                     nw;
      int                     ne;
      int                     i;
      int                     k;
      bit                     mid_pause_done;
      logic [ORIENT_BITS-1:0] palette [3];

      // The grid is all zero after reset.
      for (i = 0; i < GRID_SIDE; i++) begin
         for (k = 0; k < GRID_SIDE; k++) begin
            grain_map[i][k] = '0;
         end
      end
      mid_pause_done = 1'b0;

      // Directed words. A corner in an all-zero field cannot move.
      queue_word(ACT_EVAL, 0, 0, 0, 0, 0);
      // Writing a new value changes the cell; writing it again does not.
      queue_word(ACT_WRITE, 0, 1, 255, 0, 0);
      queue_word(ACT_WRITE, 0, 1, 255, 65535, 1);
      queue_word(ACT_WRITE, 1, 0, 255, 0, 0);
      // Corner at (0,0): the 255 candidate has lower energy and is taken.
      queue_word(ACT_EVAL, 0, 0, 0, 0, 1);
      // Opposite corner set up for equal energies: own 7, neighbors 9, 7 and 0.
      queue_word(ACT_WRITE, 63, 63, 7, 0, 0);
      queue_word(ACT_WRITE, 63, 62, 9, 0, 0);
      queue_word(ACT_WRITE, 62, 63, 7, 0, 0);
      // Equal energy with the coin set: the cell keeps its orientation.
      queue_word(ACT_EVAL, 63, 63, 0, 65535, 1);
      // The pick lands on a candidate equal to the cell's own orientation.
      queue_word(ACT_EVAL, 63, 63, 0, 1, 0);
      // Equal energy with the coin clear: the candidate is taken.
      queue_word(ACT_EVAL, 63, 63, 0, 65535, 0);
      // Interior cell at (10,10): five neighbors at 5, two at 0, the last one at 3.
      queue_word(ACT_WRITE, 10, 11, 5, 0, 0);
      queue_word(ACT_WRITE, 10, 9, 5, 0, 0);
      queue_word(ACT_WRITE, 11, 10, 5, 0, 0);
      queue_word(ACT_WRITE, 9, 10, 5, 0, 0);
      queue_word(ACT_WRITE, 11, 11, 5, 0, 0);
      queue_word(ACT_WRITE, 9, 9, 3, 0, 0);
      // Viable, but the pick has higher energy than the cell, so nothing moves.
      queue_word(ACT_EVAL, 10, 10, 0, 7, 0);
      // Lower energy pick at the first neighbor.
      queue_word(ACT_EVAL, 10, 10, 0, 0, 1);
      // Edge cells with five neighbors.
      queue_word(ACT_EVAL, 0, 32, 0, 12345, 0);
      queue_word(ACT_WRITE, 63, 0, 128, 0, 0);
      queue_word(ACT_EVAL, 62, 0, 0, 4, 0);
      queue_word(ACT_EVAL, 32, 63, 0, 65535, 0);

      // The first random word waits for the directed part to drain completely.
      pause_next = 1'b1;

      // Random part. Most of it comes as small patches: a few writes from a small palette
      // around one spot, often on an edge or corner, then evaluates in the same spot, so
      // that ties, lower energies and real moves all happen. The rest is free noise.
      while (words_built < WORD_TOTAL) begin
         if (words_built >= 600 && !mid_pause_done) begin
            pause_next = 1'b1;
            mid_pause_done = 1'b1;
         end
         if ($urandom_range(0, 99) < 15) begin
            queue_word($urandom_range(0, 1) ? ACT_EVAL : ACT_WRITE,
                       $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 255), $urandom_range(0, 65535),
                       $urandom_range(0, 1));
         end else begin
            case ($urandom_range(0, 3))
               0: bx = 0;
               1: bx = GRID_SIDE - 1;
               default: bx = $urandom_range(0, GRID_SIDE - 1);
            endcase
            case ($urandom_range(0, 3))
               0: by = 0;
               1: by = GRID_SIDE - 1;
               default: by = $urandom_range(0, GRID_SIDE - 1);
            endcase
            npal = $urandom_range(2, 3);
            for (i = 0; i < npal; i++) begin
               case ($urandom_range(0, 7))
                  0: palette[i] = '0;
                  1: palette[i] = '1;
                  default: palette[i] = ORIENT_BITS'($urandom);
               endcase
            end
            nw = $urandom_range(1, 6);
            ne = $urandom_range(2, 6);
            for (i = 0; i < nw + ne; i++) begin
               cx = bx + $urandom_range(0, 2) - 1;
               cy = by + $urandom_range(0, 2) - 1;
               if (cx < 0) cx = 0;
               if (cx > GRID_SIDE - 1) cx = GRID_SIDE - 1;
               if (cy < 0) cy = 0;
               if (cy > GRID_SIDE - 1) cy = GRID_SIDE - 1;
               queue_word((i < nw) ? ACT_WRITE : ACT_EVAL, cx, cy,
                          palette[$urandom_range(0, npal - 1)],
                          $urandom_range(0, 65535), $urandom_range(0, 1));
            end
         end
      end

      // Reset is held and then released; the block then clears its grid before it takes words.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every word to be taken and every result to come back, then let the
      // block settle before judging the run.
      while (pending_words.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/gou_pkg.sv
design/gou_front.sv
design/gou_queue.sv
design/gou_back.sv
design/grain_orientation_update.sv
design/gou_checker.sv
verif/grain_orientation_update_tb.sv
